FILE: hdl/throttle_ramp_sequencer_defines.svh
// Assertion macros used by throttle_ramp_sequencer.sv.
`ifndef THROTTLE_RAMP_SEQUENCER_DEFINES_SVH
`define THROTTLE_RAMP_SEQUENCER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TRS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/trs_pkg.sv
package trs_pkg;

  localparam int unsigned POSITION_COUNT = 100;

  localparam int unsigned POS_W  = 7;
  localparam int unsigned DATA_W = 16;
  localparam int unsigned UPC_W  = 6;

  // Command codes
  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_RAMP   = 3'd1;
  localparam logic [2:0] CMD_STEP   = 3'd2;
  localparam logic [2:0] CMD_WAIT   = 3'd3;
  localparam logic [2:0] CMD_REPORT = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BOUNDS = 2'd1;
  localparam logic [1:0] ST_TIME   = 2'd2;
  localparam logic [1:0] ST_BUSY   = 2'd3;

  typedef enum logic [4:0] {
    U_NOP,
    U_FETCH,
    U_REPORT,
    U_ST_BUSY,
    U_SET_DONE,
    U_RAMP_INIT,
    U_DIV_START,
    U_RAMP_GO,
    U_SET_POS,
    U_ST_BOUNDS,
    U_ST_TIME,
    U_POS_STEP,
    U_WAIT_INIT,
    U_SE_INC,
    U_RAMP_MOVE,
    U_FINISH,
    U_WAIT_INC,
    U_EMIT
  } uop_e;

  typedef enum logic [4:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ITEM,
    C_IS_TICK,
    C_IS_UNK,
    C_BUSY,
    C_IS_RAMP,
    C_IS_STEP,
    C_IS_WAIT,
    C_ARG_OOR,
    C_NO_TIME,
    C_TIME_BAD,
    C_ARG_AT_POS,
    C_DIV_BUSY,
    C_MODE_RAMP,
    C_MODE_WAIT,
    C_NOT_DUE,
    C_STEPS_LEFT,
    C_STEP_OOR,
    C_WAIT_RUN,
    C_OUT_FULL
  } cond_e;

  typedef struct packed {
    uop_e             uop;
    cond_e            cond;
    logic [UPC_W-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    logic no_item;
    logic is_tick;
    logic is_unk;
    logic busy;
    logic is_ramp;
    logic is_step;
    logic is_wait;
    logic arg_oor;
    logic no_time;
    logic time_bad;
    logic arg_at_pos;
    logic div_busy;
    logic mode_ramp;
    logic mode_wait;
    logic not_due;
    logic steps_left;
    logic step_oor;
    logic wait_run;
    logic out_full;
  } trs_flags_t;

  // Program entry points
  localparam logic [UPC_W-1:0] A_FETCH    = 6'd0;
  localparam logic [UPC_W-1:0] A_REJ      = 6'd8;
  localparam logic [UPC_W-1:0] A_RAMP     = 6'd9;
  localparam logic [UPC_W-1:0] A_DIV_WAIT = 6'd14;
  localparam logic [UPC_W-1:0] A_SETNOW   = 6'd16;
  localparam logic [UPC_W-1:0] A_ERR_BND  = 6'd17;
  localparam logic [UPC_W-1:0] A_ERR_TIME = 6'd18;
  localparam logic [UPC_W-1:0] A_STEP     = 6'd19;
  localparam logic [UPC_W-1:0] A_WAIT     = 6'd21;
  localparam logic [UPC_W-1:0] A_TICK     = 6'd23;
  localparam logic [UPC_W-1:0] A_TRAMP    = 6'd26;
  localparam logic [UPC_W-1:0] A_TR_CHK   = 6'd29;
  localparam logic [UPC_W-1:0] A_TWAIT    = 6'd31;
  localparam logic [UPC_W-1:0] A_EMIT     = 6'd34;

  function automatic ctrl_word_t mk_cw(input uop_e u, input cond_e c,
                                       input logic [UPC_W-1:0] t);
    ctrl_word_t w;
    w.uop    = u;
    w.cond   = c;
    w.target = t;
    return w;
  endfunction

  // Microprogram: jump to target when the condition holds, else fall through.
  function automatic ctrl_word_t ucode_rom(input logic [UPC_W-1:0] addr);
    ctrl_word_t w;
    unique case (addr)
      6'd0:  w = mk_cw(U_FETCH,     C_NO_ITEM,    A_FETCH);
      6'd1:  w = mk_cw(U_NOP,       C_IS_TICK,    A_TICK);
      6'd2:  w = mk_cw(U_NOP,       C_IS_UNK,     A_EMIT);
      6'd3:  w = mk_cw(U_NOP,       C_BUSY,       A_REJ);
      6'd4:  w = mk_cw(U_NOP,       C_IS_RAMP,    A_RAMP);
      6'd5:  w = mk_cw(U_NOP,       C_IS_STEP,    A_STEP);
      6'd6:  w = mk_cw(U_NOP,       C_IS_WAIT,    A_WAIT);
      6'd7:  w = mk_cw(U_REPORT,    C_ALWAYS,     A_EMIT);
      6'd8:  w = mk_cw(U_ST_BUSY,   C_ALWAYS,     A_EMIT);
      6'd9:  w = mk_cw(U_SET_DONE,  C_ARG_OOR,    A_ERR_BND);
      6'd10: w = mk_cw(U_NOP,       C_NO_TIME,    A_SETNOW);
      6'd11: w = mk_cw(U_NOP,       C_TIME_BAD,   A_ERR_TIME);
      6'd12: w = mk_cw(U_RAMP_INIT, C_ARG_AT_POS, A_EMIT);
      6'd13: w = mk_cw(U_DIV_START, C_NEVER,      A_FETCH);
      6'd14: w = mk_cw(U_NOP,       C_DIV_BUSY,   A_DIV_WAIT);
      6'd15: w = mk_cw(U_RAMP_GO,   C_ALWAYS,     A_EMIT);
      6'd16: w = mk_cw(U_SET_POS,   C_ALWAYS,     A_EMIT);
      6'd17: w = mk_cw(U_ST_BOUNDS, C_ALWAYS,     A_EMIT);
      6'd18: w = mk_cw(U_ST_TIME,   C_ALWAYS,     A_EMIT);
      6'd19: w = mk_cw(U_SET_DONE,  C_STEP_OOR,   A_ERR_BND);
      6'd20: w = mk_cw(U_POS_STEP,  C_ALWAYS,     A_EMIT);
      6'd21: w = mk_cw(U_NOP,       C_TIME_BAD,   A_ERR_TIME);
      6'd22: w = mk_cw(U_WAIT_INIT, C_ALWAYS,     A_EMIT);
      6'd23: w = mk_cw(U_NOP,       C_MODE_RAMP,  A_TRAMP);
      6'd24: w = mk_cw(U_NOP,       C_MODE_WAIT,  A_TWAIT);
      6'd25: w = mk_cw(U_NOP,       C_ALWAYS,     A_EMIT);
      6'd26: w = mk_cw(U_SE_INC,    C_NEVER,      A_FETCH);
      6'd27: w = mk_cw(U_NOP,       C_NOT_DUE,    A_TR_CHK);
      6'd28: w = mk_cw(U_RAMP_MOVE, C_NEVER,      A_FETCH);
      6'd29: w = mk_cw(U_NOP,       C_STEPS_LEFT, A_EMIT);
      6'd30: w = mk_cw(U_FINISH,    C_ALWAYS,     A_EMIT);
      6'd31: w = mk_cw(U_WAIT_INC,  C_NEVER,      A_FETCH);
      6'd32: w = mk_cw(U_NOP,       C_WAIT_RUN,   A_EMIT);
      6'd33: w = mk_cw(U_FINISH,    C_ALWAYS,     A_EMIT);
      6'd34: w = mk_cw(U_EMIT,      C_OUT_FULL,   A_EMIT);
      6'd35: w = mk_cw(U_NOP,       C_ALWAYS,     A_FETCH);
      default: w = mk_cw(U_NOP,     C_ALWAYS,     A_FETCH);
    endcase
    return w;
  endfunction

endpackage

FILE: hdl/trs_if.sv
interface trs_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic signed [15:0] arg_value;
  logic signed [15:0] time_ms;
  logic               has_time;

  modport source (output valid, cmd, arg_value, time_ms, has_time, input ready);
  modport sink   (input valid, cmd, arg_value, time_ms, has_time, output ready);
endinterface

interface trs_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] position;
  logic [1:0] status;
  logic       cmd_done;
  logic       report;

  modport source (output valid, position, status, cmd_done, report, input ready);
  modport sink   (input valid, position, status, cmd_done, report, output ready);
endinterface

FILE: hdl/trs_divider.sv
// Restoring divider, one quotient bit per cycle.
module trs_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] dividend_i,
  input  logic [6:0]  divisor_i,
  output logic        busy_o,
  output logic [15:0] quotient_o
);

  logic [4:0]  cnt_q, cnt_d;
  logic [15:0] dq_q, dq_d;
  logic [6:0]  rem_q, rem_d;
  logic [6:0]  dvs_q, dvs_d;
  logic [7:0]  rem_sh;
  logic        fits;

  assign rem_sh = {rem_q, dq_q[15]};
  assign fits   = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    cnt_d = cnt_q;
    dq_d  = dq_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    if (start_i) begin
      cnt_d = 5'd16;
      dq_d  = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 5'd1;
      dq_d  = {dq_q[14:0], fits};
      rem_d = fits ? 7'(rem_sh - {1'b0, dvs_q}) : rem_sh[6:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = cnt_q != '0;
  assign quotient_o = dq_q;

endmodule

FILE: hdl/trs_sequencer.sv
// Step counter over the microprogram, with conditional jumps.
module trs_sequencer
  import trs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  trs_flags_t flags_i,
  output ctrl_word_t cw_o
);

  logic [UPC_W-1:0] upc_q, upc_d;
  ctrl_word_t       cw;
  logic             take;

  assign cw = ucode_rom(upc_q);

  always_comb begin
    unique case (cw.cond)
      C_NEVER:      take = 1'b0;
      C_ALWAYS:     take = 1'b1;
      C_NO_ITEM:    take = flags_i.no_item;
      C_IS_TICK:    take = flags_i.is_tick;
      C_IS_UNK:     take = flags_i.is_unk;
      C_BUSY:       take = flags_i.busy;
      C_IS_RAMP:    take = flags_i.is_ramp;
      C_IS_STEP:    take = flags_i.is_step;
      C_IS_WAIT:    take = flags_i.is_wait;
      C_ARG_OOR:    take = flags_i.arg_oor;
      C_NO_TIME:    take = flags_i.no_time;
      C_TIME_BAD:   take = flags_i.time_bad;
      C_ARG_AT_POS: take = flags_i.arg_at_pos;
      C_DIV_BUSY:   take = flags_i.div_busy;
      C_MODE_RAMP:  take = flags_i.mode_ramp;
      C_MODE_WAIT:  take = flags_i.mode_wait;
      C_NOT_DUE:    take = flags_i.not_due;
      C_STEPS_LEFT: take = flags_i.steps_left;
      C_STEP_OOR:   take = flags_i.step_oor;
      C_WAIT_RUN:   take = flags_i.wait_run;
      C_OUT_FULL:   take = flags_i.out_full;
      default:      take = 1'b1;
    endcase
    upc_d = take ? cw.target : upc_q + 6'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= A_FETCH;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign cw_o = cw;

endmodule

FILE: hdl/throttle_ramp_sequencer.sv
// Channel  Dir  Word contents
// -------  ---  -----------------------------------------------
// in_i     in   cmd[2:0], arg_value[15:0] s, time_ms[15:0] s, has_time
// out_o    out  position[6:0], status[1:0], cmd_done, report
//
// One word in, one word out. A microprogram walks each word; a timed ramp also
// waits on the serial divider that forms the step interval.
// rst_ni is asynchronous and clears the sequencer and all ramp/wait state.
// A finished word sits in the output register; the next input word is taken
// meanwhile, and only the emit step waits on out_o.ready.
`include "throttle_ramp_sequencer_defines.svh"

module throttle_ramp_sequencer
  import trs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  trs_in_if.sink    in_i,
  trs_out_if.source out_o
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_RAMP,
    MODE_WAIT
  } mode_e;

  ctrl_word_t cw;
  trs_flags_t flags;

  // Model state
  mode_e             mode_q, mode_d;
  logic [POS_W-1:0]  pos_now_q, pos_now_d;
  logic [POS_W-1:0]  goal_pos_q, goal_pos_d;
  logic [POS_W-1:0]  steps_left_q, steps_left_d;
  logic [DATA_W-1:0] step_interval_q, step_interval_d;
  logic [DATA_W-1:0] step_elapsed_q, step_elapsed_d;
  logic [DATA_W-1:0] wait_length_q, wait_length_d;
  logic [DATA_W-1:0] wait_elapsed_q, wait_elapsed_d;

  // Latched word and result under construction
  logic [2:0]        cmd_q, cmd_d;
  logic [DATA_W-1:0] arg_q, arg_d;
  logic [DATA_W-1:0] tms_q, tms_d;
  logic              has_time_q, has_time_d;
  logic [POS_W-1:0]  start_pos_q, start_pos_d;
  logic [1:0]        res_status_q, res_status_d;
  logic              res_done_q, res_done_d;
  logic              res_rep_q, res_rep_d;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic [POS_W-1:0]  out_pos_q, out_pos_d;
  logic [1:0]        out_status_q, out_status_d;
  logic              out_done_q, out_done_d;
  logic              out_rep_q, out_rep_d;

  logic              in_fire;
  logic              out_full;
  logic              emit_fire;
  logic              div_start;
  logic              div_busy;
  logic [DATA_W-1:0] div_quo;
  logic [POS_W-1:0]  arg_pos;
  logic [POS_W-1:0]  ramp_dist;
  logic [16:0]       step_sum;
  logic              arg_oor, step_oor, time_bad, due;
  logic              ramp_at_fetch;

  trs_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .cw_o    (cw)
  );

  trs_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (tms_q),
    .divisor_i  (steps_left_q),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  assign in_i.ready = (cw.uop == U_FETCH);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_full   = out_valid_q && !out_o.ready;
  assign emit_fire  = (cw.uop == U_EMIT) && !out_full;
  assign div_start  = (cw.uop == U_DIV_START);

  // Target must be 0..POSITION_COUNT-1; only then is arg_pos meaningful.
  assign arg_oor   = arg_q[15] || (arg_q[14:0] >= 15'(POSITION_COUNT));
  assign arg_pos   = arg_q[POS_W-1:0];
  assign ramp_dist = (arg_pos > pos_now_q) ? arg_pos - pos_now_q : pos_now_q - arg_pos;
  // Signed add of the delta, 17 bits so it cannot wrap.
  assign step_sum  = {10'd0, pos_now_q} + {arg_q[15], arg_q};
  assign step_oor  = step_sum[16] || (step_sum[15:0] >= 16'(POSITION_COUNT));
  assign time_bad  = tms_q[15] || (tms_q == '0);
  // A zero interval behaves as one: the compare is true on every tick.
  assign due       = (steps_left_q != '0) && (step_elapsed_q >= step_interval_q);
  // Between words a running ramp always has steps left.
  assign ramp_at_fetch = in_i.ready && (mode_q == MODE_RAMP);

  always_comb begin
    flags.no_item    = !in_i.valid;
    flags.is_tick    = cmd_q == CMD_TICK;
    flags.is_unk     = cmd_q > CMD_REPORT;
    flags.busy       = mode_q != MODE_IDLE;
    flags.is_ramp    = cmd_q == CMD_RAMP;
    flags.is_step    = cmd_q == CMD_STEP;
    flags.is_wait    = cmd_q == CMD_WAIT;
    flags.arg_oor    = arg_oor;
    flags.no_time    = !has_time_q;
    flags.time_bad   = time_bad;
    flags.arg_at_pos = arg_pos == pos_now_q;
    flags.div_busy   = div_busy;
    flags.mode_ramp  = mode_q == MODE_RAMP;
    flags.mode_wait  = mode_q == MODE_WAIT;
    flags.not_due    = !due;
    flags.steps_left = steps_left_q != '0;
    flags.step_oor   = step_oor;
    flags.wait_run   = wait_elapsed_q < wait_length_q;
    flags.out_full   = out_full;
  end

  // Datapath driven by the current control word.
  always_comb begin
    mode_d          = mode_q;
    pos_now_d       = pos_now_q;
    goal_pos_d      = goal_pos_q;
    steps_left_d    = steps_left_q;
    step_interval_d = step_interval_q;
    step_elapsed_d  = step_elapsed_q;
    wait_length_d   = wait_length_q;
    wait_elapsed_d  = wait_elapsed_q;
    cmd_d           = cmd_q;
    arg_d           = arg_q;
    tms_d           = tms_q;
    has_time_d      = has_time_q;
    start_pos_d     = start_pos_q;
    res_status_d    = res_status_q;
    res_done_d      = res_done_q;
    res_rep_d       = res_rep_q;

    unique case (cw.uop)
      U_FETCH: begin
        if (in_fire) begin
          cmd_d        = in_i.cmd;
          arg_d        = in_i.arg_value;
          tms_d        = in_i.time_ms;
          has_time_d   = in_i.has_time;
          start_pos_d  = pos_now_q;
          res_status_d = ST_OK;
          res_done_d   = 1'b0;
          res_rep_d    = 1'b0;
        end
      end
      U_REPORT: begin
        res_rep_d  = 1'b1;
        res_done_d = 1'b1;
      end
      U_ST_BUSY:  res_status_d = ST_BUSY;
      U_SET_DONE: res_done_d = 1'b1;
      U_RAMP_INIT: begin
        goal_pos_d   = arg_pos;
        steps_left_d = ramp_dist;
      end
      U_RAMP_GO: begin
        step_interval_d = div_quo;
        step_elapsed_d  = '0;
        mode_d          = MODE_RAMP;
        res_done_d      = 1'b0;
      end
      U_SET_POS: begin
        pos_now_d  = arg_pos;
        goal_pos_d = arg_pos;
      end
      U_ST_BOUNDS: begin
        res_status_d = ST_BOUNDS;
        res_done_d   = 1'b1;
      end
      U_ST_TIME: begin
        res_status_d = ST_TIME;
        res_done_d   = 1'b1;
      end
      U_POS_STEP: pos_now_d = step_sum[POS_W-1:0];
      U_WAIT_INIT: begin
        wait_length_d  = tms_q;
        wait_elapsed_d = '0;
        mode_d         = MODE_WAIT;
      end
      U_SE_INC: step_elapsed_d = step_elapsed_q + 16'd1;
      U_RAMP_MOVE: begin
        if (goal_pos_q > pos_now_q) begin
          pos_now_d = pos_now_q + 7'd1;
        end else if (pos_now_q != '0) begin
          pos_now_d = pos_now_q - 7'd1;
        end
        steps_left_d   = steps_left_q - 7'd1;
        step_elapsed_d = '0;
      end
      U_FINISH: begin
        res_done_d = 1'b1;
        mode_d     = MODE_IDLE;
      end
      U_WAIT_INC: begin
        if (wait_elapsed_q < wait_length_q) begin
          wait_elapsed_d = wait_elapsed_q + 16'd1;
        end
      end
      default: ;
    endcase
  end

  // Output register: loaded by the emit step, freed by the sink.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_pos_d    = out_pos_q;
    out_status_d = out_status_q;
    out_done_d   = out_done_q;
    out_rep_d    = out_rep_q;
    if (emit_fire) begin
      out_valid_d  = 1'b1;
      out_pos_d    = pos_now_q;
      out_status_d = res_status_q;
      out_done_d   = res_done_q;
      out_rep_d    = res_rep_q || (pos_now_q != start_pos_q);
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q          <= MODE_IDLE;
      pos_now_q       <= '0;
      goal_pos_q      <= '0;
      steps_left_q    <= '0;
      step_interval_q <= '0;
      step_elapsed_q  <= '0;
      wait_length_q   <= '0;
      wait_elapsed_q  <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      mode_q          <= mode_d;
      pos_now_q       <= pos_now_d;
      goal_pos_q      <= goal_pos_d;
      steps_left_q    <= steps_left_d;
      step_interval_q <= step_interval_d;
      step_elapsed_q  <= step_elapsed_d;
      wait_length_q   <= wait_length_d;
      wait_elapsed_q  <= wait_elapsed_d;
      out_valid_q     <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    arg_q        <= arg_d;
    tms_q        <= tms_d;
    has_time_q   <= has_time_d;
    start_pos_q  <= start_pos_d;
    res_status_q <= res_status_d;
    res_done_q   <= res_done_d;
    res_rep_q    <= res_rep_d;
    out_pos_q    <= out_pos_d;
    out_status_q <= out_status_d;
    out_done_q   <= out_done_d;
    out_rep_q    <= out_rep_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.position = out_pos_q;
  assign out_o.status   = out_status_q;
  assign out_o.cmd_done = out_done_q;
  assign out_o.report   = out_rep_q;

  `TRS_ASSERT_SAME(a_ramp_has_steps, ramp_at_fetch, steps_left_q != '0, "ramp with no steps")
  `TRS_ASSERT_SAME(a_pos_in_range, 1'b1, {1'b0, pos_now_q} < 8'(POSITION_COUNT), "position range")
  `TRS_ASSERT_SAME(a_busy_not_done, emit_fire && (res_status_q == ST_BUSY), !res_done_q, "busy done")
  `TRS_ASSERT_NEXT(a_div_runs, div_start, div_busy, "divider did not start")
  `TRS_ASSERT_SAME(a_wait_bound, mode_q == MODE_WAIT, wait_elapsed_q <= wait_length_q, "wait overrun")

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import trs_pkg::*;

  // Command codes the block ignores in every mode.
  localparam logic [2:0] CMD_UNUSED_MIN = CMD_REPORT + 3'd1;
  localparam logic [2:0] CMD_UNUSED_MAX = 3'd7;
  localparam int         POS_TOP        = POSITION_COUNT - 1;
  localparam int         PRINT_LIMIT    = 20;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_RAMP,
    MODE_WAIT
  } seq_mode_e;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [15:0] arg_value;
    logic signed [15:0] time_ms;
    logic               has_time;
  } cmd_word_t;

  typedef struct packed {
    logic [6:0] position;
    logic [1:0] status;
    logic       cmd_done;
    logic       report;
  } result_word_t;

  // Tracks the wiper and ramp/wait timers, and holds the words still owed by the block.
  class throttle_scoreboard;
    seq_mode_e    mode;
    logic [6:0]   pos_now;
    logic [6:0]   goal_pos;
    logic [6:0]   steps_left;
    logic [15:0]  step_interval;
    logic [15:0]  step_elapsed;
    logic [15:0]  wait_length;
    logic [15:0]  wait_elapsed;
    result_word_t owed_words[$];
    int unsigned  mismatches;
    int unsigned  words_seen;

    function new();
      mode          = MODE_IDLE;
      pos_now       = '0;
      goal_pos      = '0;
      steps_left    = '0;
      step_interval = '0;
      step_elapsed  = '0;
      wait_length   = '0;
      wait_elapsed  = '0;
      mismatches    = 0;
      words_seen    = 0;
    endfunction

    // Apply one accepted command word and return the word the block must produce.
    function result_word_t advance_wiper(input cmd_word_t w);
      result_word_t r;
      logic [6:0]   start_pos;
      int           arg;
      int           tms;
      int           new_pos;
      int           span;
      r         = '0;
      r.status  = ST_OK;
      start_pos = pos_now;
      arg       = w.arg_value;
      tms       = w.time_ms;
      if (w.cmd == CMD_TICK) begin
        if (mode == MODE_RAMP) begin
          step_elapsed = step_elapsed + 16'd1;
          if (steps_left != 0 && step_elapsed >= step_interval) begin
            if (goal_pos > pos_now) begin
              pos_now = pos_now + 7'd1;
            end else if (pos_now > 0) begin
              pos_now = pos_now - 7'd1;
            end
            steps_left   = steps_left - 7'd1;
            step_elapsed = '0;
          end
          if (steps_left == 0) begin
            r.cmd_done = 1'b1;
            mode       = MODE_IDLE;
          end
        end else if (mode == MODE_WAIT) begin
          if (wait_elapsed < wait_length) begin
            wait_elapsed = wait_elapsed + 16'd1;
          end
          if (wait_elapsed >= wait_length) begin
            r.cmd_done = 1'b1;
            mode       = MODE_IDLE;
          end
        end
      end else if (w.cmd <= CMD_REPORT && mode != MODE_IDLE) begin
        r.status = ST_BUSY;
      end else if (w.cmd == CMD_RAMP) begin
        r.cmd_done = 1'b1;
        if (arg < 0 || arg > POS_TOP) begin
          r.status = ST_BOUNDS;
        end else if (!w.has_time) begin
          pos_now  = 7'(arg);
          goal_pos = 7'(arg);
        end else if (tms <= 0) begin
          r.status = ST_TIME;
        end else begin
          span       = (arg > int'(pos_now)) ? arg - int'(pos_now) : int'(pos_now) - arg;
          goal_pos   = 7'(arg);
          steps_left = 7'(span);
          if (span != 0) begin
            step_interval = 16'(tms / span);
            step_elapsed  = '0;
            mode          = MODE_RAMP;
            r.cmd_done    = 1'b0;
          end
        end
      end else if (w.cmd == CMD_STEP) begin
        new_pos    = int'(pos_now) + arg;
        r.cmd_done = 1'b1;
        if (new_pos < 0 || new_pos > POS_TOP) begin
          r.status = ST_BOUNDS;
        end else begin
          pos_now = 7'(new_pos);
        end
      end else if (w.cmd == CMD_WAIT) begin
        if (tms <= 0) begin
          r.status   = ST_TIME;
          r.cmd_done = 1'b1;
        end else begin
          wait_length  = 16'(tms);
          wait_elapsed = '0;
          mode         = MODE_WAIT;
        end
      end else if (w.cmd == CMD_REPORT) begin
        r.report   = 1'b1;
        r.cmd_done = 1'b1;
      end
      if (pos_now != start_pos) begin
        r.report = 1'b1;
      end
      r.position = pos_now;
      return r;
    endfunction

    function void note_word(input cmd_word_t w);
      owed_words.push_back(advance_wiper(w));
    endfunction

    task flag_mismatch(input string what);
      if (mismatches < PRINT_LIMIT) begin
        $display("%0t: mismatch on output word %0d: %s", $realtime, words_seen, what);
      end
      mismatches++;
    endtask

    task check_word(input result_word_t got);
      result_word_t want;
      words_seen++;
      if (owed_words.size() == 0) begin
        flag_mismatch("word arrived with none owed");
      end else begin
        want = owed_words.pop_front();
        if (got.position !== want.position) begin
          flag_mismatch($sformatf("position %0d, want %0d", got.position, want.position));
        end
        if (got.status !== want.status) begin
          flag_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
        end
        if (got.cmd_done !== want.cmd_done) begin
          flag_mismatch($sformatf("cmd_done %0b, want %0b", got.cmd_done, want.cmd_done));
        end
        if (got.report !== want.report) begin
          flag_mismatch($sformatf("report %0b, want %0b", got.report, want.report));
        end
      end
    endtask

    task close_out();
      if (owed_words.size() != 0) begin
        flag_mismatch($sformatf("%0d words never came out", owed_words.size()));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  trs_in_if  in_ch ();
  trs_out_if out_ch ();

  throttle_ramp_sequencer dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  throttle_scoreboard sb;

  // Per-cycle idle odds, in percent; only changed at a rising edge.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  // Remaining cycles of a forced receiver hold-off.
  int unsigned recv_hold;

  // 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: ready moves on the falling edge. A hold-off overrides the random idling
  // so the block backs up into its input.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (recv_hold != 0) begin
      out_ch.ready <= 1'b0;
      recv_hold = recv_hold - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Output monitor: sampled on the rising edge, before the block updates.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      sb.check_word(result_word_t'{out_ch.position, out_ch.status,
                                   out_ch.cmd_done, out_ch.report});
    end
  end

  function automatic cmd_word_t word_of(input logic [2:0] c, input int a, input int t,
                                        input bit h);
    cmd_word_t w;
    w.cmd       = c;
    w.arg_value = 16'(a);
    w.time_ms   = 16'(t);
    w.has_time  = h;
    return w;
  endfunction

  // Random command word. While a ramp or wait runs, mostly ticks so the command
  // actually completes; while idle, a mix of commands with mostly legal arguments.
  function automatic cmd_word_t pick_word();
    cmd_word_t w;
    int        roll;
    int        sub;
    int        tgt;
    int        span;
    int        t;
    int        pos;
    pos         = sb.pos_now;
    w.cmd       = CMD_TICK;
    w.arg_value = 16'($urandom);
    w.time_ms   = 16'($urandom);
    w.has_time  = 1'($urandom);
    roll        = $urandom_range(99);
    if (sb.mode != MODE_IDLE) begin
      if (roll >= 95) begin
        w.cmd = CMD_UNUSED_MIN + 3'($urandom_range(0, CMD_UNUSED_MAX - CMD_UNUSED_MIN));
      end else if (roll >= 85) begin
        // gets rejected as busy
        w.cmd = 3'($urandom_range(CMD_RAMP, CMD_REPORT));
      end
    end else if (roll < 10) begin
      w.cmd = CMD_TICK;
    end else if (roll < 15) begin
      w.cmd = CMD_UNUSED_MIN + 3'($urandom_range(0, CMD_UNUSED_MAX - CMD_UNUSED_MIN));
    end else if (roll < 45) begin
      w.cmd = CMD_RAMP;
      tgt   = ($urandom_range(99) < 85) ? $urandom_range(0, POS_TOP) : int'($signed(16'($urandom)));
      w.arg_value = 16'(tgt);
      w.has_time  = ($urandom_range(99) < 85);
      span = (tgt > pos) ? tgt - pos : pos - tgt;
      sub  = $urandom_range(99);
      if (tgt < 0 || tgt > POS_TOP || span == 0) begin
        t = int'($signed(16'($urandom)));
      end else if (sub < 20) begin
        t = $urandom_range(1, span + 1);
      end else if (sub < 85) begin
        t = $urandom_range(span, 4 * span + 8);
      end else if (sub < 95) begin
        t = $urandom_range(1, 300);
      end else begin
        t = -int'($urandom_range(0, 32768));
      end
      w.time_ms = 16'(t);
    end else if (roll < 65) begin
      w.cmd = CMD_STEP;
      sub   = $urandom_range(99);
      if (sub < 80) begin
        w.arg_value = 16'(int'($urandom_range(0, 40)) - 20);
      end else if (sub < 95) begin
        w.arg_value = 16'(int'($urandom_range(0, POS_TOP)) - pos);
      end
    end else if (roll < 85) begin
      w.cmd = CMD_WAIT;
      sub   = $urandom_range(99);
      if (sub < 85) begin
        w.time_ms = 16'($urandom_range(1, 30));
      end else if (sub < 95) begin
        w.time_ms = 16'(-int'($urandom_range(0, 32768)));
      end else begin
        w.time_ms = 16'($urandom_range(31, 200));
      end
    end else begin
      w.cmd = CMD_REPORT;
    end
    return w;
  endfunction

  // Offer one word, entered and left on a falling edge. valid only drops
  // when an idle gap is taken, so back-to-back words keep it high.
  task automatic send_word(input cmd_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= w.cmd;
    in_ch.arg_value <= w.arg_value;
    in_ch.time_ms   <= w.time_ms;
    in_ch.has_time  <= w.has_time;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_word(w);
    @(negedge clk);
  endtask

  // Stop offering until every owed word has come out.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.owed_words.size() != 0) @(negedge clk);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    @(posedge clk);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    @(negedge clk);
  endtask

  task automatic hold_receiver(input int unsigned cycles);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    recv_hold = cycles;
    @(negedge clk);
  endtask

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("tb failed");
    $finish;
  end

  initial begin
    sb              = new();
    send_idle_pct   = 30;
    recv_idle_pct   = 53;
    recv_hold       = 0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.cmd       = CMD_TICK;
    in_ch.arg_value = '0;
    in_ch.time_ms   = '0;
    in_ch.has_time  = 1'b0;
    out_ch.ready    = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // --- directed: field extremes, error order, busy, zero-step and short ramps ---
    send_word(word_of(CMD_REPORT, 0, 0, 0));          // report at reset position
    send_word(word_of(CMD_RAMP, POS_TOP, 0, 0));      // set top at once, no time
    send_word(word_of(CMD_RAMP, POS_TOP, 32767, 1));  // zero-step ramp, done at once
    send_word(word_of(CMD_STEP, 1, 0, 0));            // past the top
    send_word(word_of(CMD_STEP, -POS_TOP, 0, 0));     // down to zero
    send_word(word_of(CMD_STEP, -1, 0, 0));           // below zero
    send_word(word_of(CMD_STEP, 32767, 0, 1));
    send_word(word_of(CMD_STEP, -32768, 0, 0));
    send_word(word_of(CMD_RAMP, -32768, 0, 1));       // bounds reported ahead of bad time
    send_word(word_of(CMD_RAMP, 32767, 5, 1));
    send_word(word_of(CMD_RAMP, POSITION_COUNT, 5, 0));
    send_word(word_of(CMD_RAMP, 50, 0, 1));           // zero time
    send_word(word_of(CMD_RAMP, 50, -32768, 1));      // negative time
    send_word(word_of(CMD_WAIT, 0, 0, 0));            // wait, zero time
    send_word(word_of(CMD_WAIT, 0, -1, 0));
    send_word(word_of(CMD_UNUSED_MAX, -1, -1, 1));    // unknown code while idle
    send_word(word_of(CMD_TICK, 0, 0, 0));            // idle tick
    send_word(word_of(CMD_RAMP, 3, 1, 1));            // time < steps: move every tick
    send_word(word_of(CMD_REPORT, 0, 0, 0));          // busy reject
    repeat (3) send_word(word_of(CMD_TICK, -1, -1, 1));
    send_word(word_of(CMD_WAIT, 0, 2, 0));
    send_word(word_of(CMD_STEP, 1, 0, 0));            // busy reject while waiting
    send_word(word_of(CMD_TICK, 0, 0, 0));
    send_word(word_of(CMD_UNUSED_MIN, 0, 0, 0));      // unknown code while waiting
    send_word(word_of(CMD_TICK, 0, 0, 0));            // wait ends

    // --- random, phase 1: sender idles lightly, receiver heavily ---
    repeat (150) send_word(pick_word());
    // Long receiver hold-off while words keep coming, so the input backs up.
    hold_receiver(400);
    repeat (260) send_word(pick_word());
    drain();

    // --- phase 2: roles swapped ---
    set_idling(53, 30);
    repeat (200) send_word(pick_word());
    drain();
    // sender paused until all owed words are out, then resumes
    repeat (200) send_word(pick_word());
    drain();

    // --- phase 3: no idling on either side ---
    set_idling(0, 0);
    repeat (410) send_word(pick_word());
    drain();

    // Let any stray word surface before the leftover check.
    repeat (40) @(negedge clk);
    sb.close_out();
    if (sb.mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/trs_pkg.sv
hdl/trs_if.sv
hdl/trs_divider.sv
hdl/trs_sequencer.sv
hdl/throttle_ramp_sequencer.sv
dv/tb.sv
